// File: rtl/core/msc_pkg.sv
// Package for the MIPS subset core: opcodes, function codes, trap codes,
// control state type, channel item types and shared constants. No dependencies.
`default_nettype none
package msc_pkg;
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_TRAP    = 6'h1a;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2b;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV  = 6'h1a;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_SLT  = 6'h2a;

	localparam logic [3:0] TRAP_NEWLINE = 4'h0;
	localparam logic [3:0] TRAP_PRINT   = 4'h1;
	localparam logic [3:0] TRAP_READ    = 4'h5;

	localparam logic [1:0] PK_NONE    = 2'd0;
	localparam logic [1:0] PK_NEWLINE = 2'd1;
	localparam logic [1:0] PK_INT     = 2'd2;
	localparam logic [1:0] PK_PROMPT  = 2'd3;

	localparam logic [31:0] DATA_BASE = 32'h1000_0000;
	localparam logic [31:0] GP_RESET  = 32'h1000_8000;
	localparam logic [4:0]  REG_GP    = 5'd28;
	localparam logic [4:0]  REG_SP    = 5'd29;
	localparam logic [4:0]  REG_RA    = 5'd31;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MULT,
		ST_DIV,
		ST_MEM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] user_value;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [1:0]  print_kind;
		logic [31:0] print_value;
		logic        halted;
		logic        unimplemented;
	} result_t;
endpackage
`default_nettype wire

// File: rtl/core/msc_chan_if.sv
// Valid/ready channel interface carrying one payload item.
// Payload type is a parameter; no package dependency.
`default_nettype none
interface msc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/msc_div.sv
// Iterative signed divider, one quotient bit per cycle.
// Depends on msc_pkg for the request and response structs.
`default_nettype none
module msc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msc_pkg::div_req_t req,
	output msc_pkg::div_rsp_t      rsp
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic        negq_q;
	logic        negr_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands are taken as magnitudes; signs are restored at the end.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.a[31] ? (32'd0 - req.a) : req.a;
			dsr_q  <= req.b[31] ? (32'd0 - req.b) : req.b;
			rem_q  <= '0;
			negq_q <= req.a[31] ^ req.b[31];
			negr_q <= req.a[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = negq_q ? (32'd0 - quo_q) : quo_q;
	assign rsp.rem  = negr_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider busy and done together");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !req.start |=> !busy_q)
		else $error("divider started without request");
endmodule
`default_nettype wire

// File: rtl/core/msc_regfile.sv
// Register file held in a synchronous memory with registered read data,
// two read ports and one write port. Reset values loaded by an init sweep.
`default_nettype none
module msc_regfile (
	input  wire logic        clk,
	input  wire logic [4:0]  ra_addr,
	input  wire logic [4:0]  rb_addr,
	output logic [31:0]      ra_data,
	output logic [31:0]      rb_data,
	input  wire logic        we,
	input  wire logic [4:0]  wa,
	input  wire logic [31:0] wd
);
	logic [31:0] mem [32];

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end
endmodule
`default_nettype wire

// File: rtl/core/mips_subset_core.sv
// MIPS subset core top level: sequencer, register file, data memory, divider.
// Depends on msc_pkg, msc_chan_if, msc_regfile and msc_div.
`default_nettype none
// One instruction item in, one result item out. An item passes through the
// states accept, register file read, execute and result; lw adds a data
// memory read state, mult a registered product state and div with a nonzero
// divisor a divide state that waits for the divider's done; div by zero
// adds none. A new item is accepted only in the cycle its predecessor's result
// item is taken or later, so a stalled result holds off the input. After reset
// a sweep loads the register file reset values; no item is accepted then. Data
// memory words read before any write return unspecified data.
module mips_subset_core #(
	parameter int DATA_WORDS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	msc_chan_if.sink         in_ch,
	msc_chan_if.source       out_ch
);
	localparam int AW = $clog2(DATA_WORDS);

	msc_pkg::state_t st_q, st_d;
	logic [31:0] pc_q;
	logic [31:0] hi_q, lo_q;
	logic        stop_q;
	logic [4:0]  init_q;
	logic [31:0] iw_q, uv_q;
	logic [31:0] res_pc_q, res_pv_q;
	logic [1:0]  res_pk_q;
	logic        res_un_q;
	logic        out_v_q;
	logic [63:0] prod_s1;

	logic [31:0] a_r, b_r;
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic [4:0]  rs, rt, rd, sh;
	logic [5:0]  op, fn;
	logic [31:0] simm, uimm, pc4, jtgt, ea, mrd, idx_full;
	logic        idx_ok;
	msc_pkg::div_req_t dreq;
	msc_pkg::div_rsp_t drsp;

	logic [31:0] dmem [DATA_WORDS];

	assign op   = iw_q[31:26];
	assign rs   = iw_q[25:21];
	assign rt   = iw_q[20:16];
	assign rd   = iw_q[15:11];
	assign sh   = iw_q[10:6];
	assign fn   = iw_q[5:0];
	assign uimm = {16'd0, iw_q[15:0]};
	assign simm = {{16{iw_q[15]}}, iw_q[15:0]};
	assign pc4  = pc_q + 32'd4;
	assign jtgt = {pc4[31:28], iw_q[25:0], 2'b00};
	assign ea   = a_r + simm;
	assign idx_full = (ea - msc_pkg::DATA_BASE) >> 2;
	assign idx_ok   = idx_full < 32'(DATA_WORDS);

	msc_regfile u_rf (
		.clk(clk), .ra_addr(rs), .rb_addr(rt), .ra_data(a_r), .rb_data(b_r),
		.we(rf_we), .wa(rf_wa), .wd(rf_wd)
	);

	assign dreq.start    = (st_q == msc_pkg::ST_EXEC) && !stop_q
		&& op == msc_pkg::OP_SPECIAL && fn == msc_pkg::FN_DIV && b_r != 32'd0;
	assign dreq.a        = a_r;
	assign dreq.b        = b_r;

	msc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Data memory: one write and one read per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (st_q == msc_pkg::ST_EXEC && !stop_q && op == msc_pkg::OP_SW && idx_ok)
			dmem[idx_full[AW-1:0]] <= b_r;
		mrd <= dmem[idx_full[AW-1:0]];
	end

	always_ff @(posedge clk) prod_s1 <= 64'($signed(a_r) * $signed(b_r));

	// Next-state logic.
	always_comb begin
		st_d = st_q;
		case (st_q)
			msc_pkg::ST_INIT: if (init_q == 5'd31) st_d = msc_pkg::ST_IDLE;
			msc_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) st_d = msc_pkg::ST_READ;
			msc_pkg::ST_READ: st_d = msc_pkg::ST_EXEC;
			msc_pkg::ST_EXEC: begin
				if (stop_q)
					st_d = msc_pkg::ST_OUT;
				else if (op == msc_pkg::OP_LW)
					st_d = msc_pkg::ST_MEM;
				else if (op == msc_pkg::OP_SPECIAL && fn == msc_pkg::FN_MULT)
					st_d = msc_pkg::ST_MULT;
				else if (dreq.start)
					st_d = msc_pkg::ST_DIV;
				else
					st_d = msc_pkg::ST_OUT;
			end
			msc_pkg::ST_MULT: st_d = msc_pkg::ST_OUT;
			msc_pkg::ST_MEM:  st_d = msc_pkg::ST_OUT;
			msc_pkg::ST_DIV:  if (drsp.done) st_d = msc_pkg::ST_OUT;
			msc_pkg::ST_OUT:  if (!out_v_q || out_ch.ready) st_d = msc_pkg::ST_IDLE;
			default: st_d = msc_pkg::ST_INIT;
		endcase
	end

	// Register file write port.
	always_comb begin
		rf_we = 1'b0;
		rf_wa = rd;
		rf_wd = 32'd0;
		if (st_q == msc_pkg::ST_INIT) begin
			rf_we = 1'b1;
			rf_wa = init_q;
			rf_wd = (init_q == msc_pkg::REG_GP) ? msc_pkg::GP_RESET :
				(init_q == msc_pkg::REG_SP) ? msc_pkg::DATA_BASE + 32'(DATA_WORDS * 4) :
				32'd0;
		end else if (st_q == msc_pkg::ST_MEM) begin
			rf_we = (rt != 5'd0);
			rf_wa = rt;
			rf_wd = idx_ok ? mrd : 32'd0;
		end else if (st_q == msc_pkg::ST_EXEC && !stop_q) begin
			case (op)
				msc_pkg::OP_SPECIAL: begin
					rf_we = 1'b1;
					case (fn)
						msc_pkg::FN_SLL:  rf_wd = b_r << sh;
						msc_pkg::FN_SRA:  rf_wd = 32'($signed(b_r) >>> sh);
						msc_pkg::FN_MFHI: rf_wd = hi_q;
						msc_pkg::FN_MFLO: rf_wd = lo_q;
						msc_pkg::FN_ADDU: rf_wd = a_r + b_r;
						msc_pkg::FN_SUBU: rf_wd = a_r - b_r;
						msc_pkg::FN_SLT:  rf_wd = {31'd0, $signed(a_r) < $signed(b_r)};
						default: rf_we = 1'b0;
					endcase
				end
				msc_pkg::OP_JAL: begin
					rf_we = 1'b1; rf_wa = msc_pkg::REG_RA; rf_wd = pc4;
				end
				msc_pkg::OP_ADDIU: begin rf_we = 1'b1; rf_wa = rt; rf_wd = a_r + simm; end
				msc_pkg::OP_ANDI:  begin rf_we = 1'b1; rf_wa = rt; rf_wd = a_r & uimm; end
				msc_pkg::OP_LUI:   begin rf_we = 1'b1; rf_wa = rt; rf_wd = {iw_q[15:0], 16'd0}; end
				msc_pkg::OP_TRAP: begin
					rf_we = iw_q[3:0] == msc_pkg::TRAP_READ;
					rf_wa = rt;
					rf_wd = uv_q;
				end
				default: rf_we = 1'b0;
			endcase
			if (rf_wa == 5'd0) rf_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= msc_pkg::ST_INIT;
			init_q  <= '0;
			pc_q    <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			stop_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == msc_pkg::ST_INIT) init_q <= init_q + 5'd1;
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			if (st_q == msc_pkg::ST_OUT && st_d == msc_pkg::ST_IDLE) begin
				out_v_q <= 1'b1;
				pc_q    <= res_pc_q;
			end
			if (st_q == msc_pkg::ST_MULT) begin
				hi_q <= prod_s1[63:32];
				lo_q <= prod_s1[31:0];
			end
			if (st_q == msc_pkg::ST_DIV && drsp.done) begin
				hi_q <= drsp.rem;
				lo_q <= drsp.quo;
			end
			if (st_q == msc_pkg::ST_EXEC && !stop_q) begin
				if (op == msc_pkg::OP_SPECIAL && fn == msc_pkg::FN_DIV && b_r == 32'd0) begin
					hi_q <= a_r;
					lo_q <= 32'hffff_ffff;
				end
				if (op == msc_pkg::OP_TRAP && iw_q[3:0] != msc_pkg::TRAP_NEWLINE
					&& iw_q[3:0] != msc_pkg::TRAP_PRINT && iw_q[3:0] != msc_pkg::TRAP_READ)
					stop_q <= 1'b1;
			end
			if (cfg_we) pc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			iw_q <= in_ch.data.instr_word;
			uv_q <= in_ch.data.user_value;
		end
		if (st_q == msc_pkg::ST_EXEC) begin
			res_pc_q <= pc4;
			res_pk_q <= msc_pkg::PK_NONE;
			res_pv_q <= 32'd0;
			res_un_q <= 1'b0;
			if (stop_q) begin
				res_pc_q <= pc_q;
			end else begin
				case (op)
					msc_pkg::OP_SPECIAL: begin
						if (fn == msc_pkg::FN_JR) res_pc_q <= a_r;
						if (!(fn == msc_pkg::FN_SLL || fn == msc_pkg::FN_SRA
							|| fn == msc_pkg::FN_JR || fn == msc_pkg::FN_MFHI
							|| fn == msc_pkg::FN_MFLO || fn == msc_pkg::FN_MULT
							|| fn == msc_pkg::FN_DIV || fn == msc_pkg::FN_ADDU
							|| fn == msc_pkg::FN_SUBU || fn == msc_pkg::FN_SLT))
							res_un_q <= 1'b1;
					end
					msc_pkg::OP_J, msc_pkg::OP_JAL: res_pc_q <= jtgt;
					msc_pkg::OP_BEQ: if (a_r == b_r) res_pc_q <= pc4 + (simm << 2);
					msc_pkg::OP_BNE: if (a_r != b_r) res_pc_q <= pc4 + (simm << 2);
					msc_pkg::OP_ADDIU, msc_pkg::OP_ANDI, msc_pkg::OP_LUI,
					msc_pkg::OP_LW, msc_pkg::OP_SW: ;
					msc_pkg::OP_TRAP: begin
						case (iw_q[3:0])
							msc_pkg::TRAP_NEWLINE: res_pk_q <= msc_pkg::PK_NEWLINE;
							msc_pkg::TRAP_PRINT: begin
								res_pk_q <= msc_pkg::PK_INT;
								res_pv_q <= a_r;
							end
							msc_pkg::TRAP_READ: res_pk_q <= msc_pkg::PK_PROMPT;
							default: ;
						endcase
					end
					default: res_un_q <= 1'b1;
				endcase
			end
		end
	end

	// The result registers are reused per item, so input waits for the old result.
	assign in_ch.ready = (st_q == msc_pkg::ST_IDLE) && (!out_v_q || out_ch.ready);
	assign out_ch.valid = out_v_q;
	assign out_ch.data.next_pc       = res_pc_q;
	assign out_ch.data.print_kind    = res_pk_q;
	assign out_ch.data.print_value   = res_pv_q;
	assign out_ch.data.halted        = stop_q;
	assign out_ch.data.unimplemented = res_un_q;

	a_result_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> st_q == msc_pkg::ST_IDLE)
		else $error("result item pending while an item is in flight");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> st_q == msc_pkg::ST_READ)
		else $error("accepted item not read");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.busy |-> st_q == msc_pkg::ST_DIV)
		else $error("divider running outside divide");
	a_no_rf_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == msc_pkg::ST_IDLE |-> !rf_we)
		else $error("register write while idle");
endmodule
`default_nettype wire
